### src/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and defaults for the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  localparam int WORD_BITS       = 32;
  localparam int NUM_PAGES_DEF   = 4096;
  localparam int MAX_RUN_DEF     = 16;
  localparam int PAGE_SHIFT_DEF  = 12;

  localparam int PAGE_IDX_W = 12;
  localparam int RUN_LEN_W  = 5;
  localparam int ADDR_W     = 64;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_MARK  = 2'd2,
    FUNC_QUERY = 2'd3
  } func_t;

  typedef struct packed {
    func_t                 func;
    logic [PAGE_IDX_W-1:0] page_index;
    logic [RUN_LEN_W-1:0]  run_length;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              ok;
    logic              page_free;
  } out_t;

  // Outcome of evaluating one map word during a run search
  typedef struct packed {
    logic       hit;
    logic [4:0] pos;  // bit of the current word where the run ends
  } scan_res_t;

endpackage

### src/bitmap_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// Bitmap page allocator: allocate a run, free, mark used and query pages.
// ----------------------------------------------------------------------------
// Free, mark used, query: the map word read on acceptance is written back (free, mark) in S_RMW, which
//   registers the result strobe. Bad index or bad run length: result strobe in the cycle after acceptance.
// Allocate: one map word per cycle through the memory read port; one item at a time.
// Reset: a clearing pass writes every map word to zero, with busy high.
//   base_address resets to zero.
// Results cannot be stalled: out_valid is high for exactly one cycle.
module bitmap_page_frame_allocator
  import bpfa_pkg::*;
#(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int MAX_RUN    = MAX_RUN_DEF,
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_t               in_item,
  output logic              out_valid,
  output out_t              out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ADDR_W-1:0] cfg_data
);

  localparam int WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PAW   = WAW + 5;
  localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);
  localparam int TAIL = NUM_PAGES % WORD_BITS;
  localparam logic [WORD_BITS-1:0] TAIL_MASK =
    (TAIL == 0) ? '1 : WORD_BITS'((64'd1 << TAIL) - 64'd1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RMW   = 5'b00100,
    S_SCAN  = 5'b01000,
    S_FIX   = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [WAW-1:0]       word_r, word_nxt;
  logic [WORD_BITS-1:0] prev_used_r, prev_used_nxt;
  logic [WORD_BITS-1:0] prev_free_r, prev_free_nxt;
  logic [WORD_BITS-1:0] prev_set_r, prev_set_nxt;
  logic                 prev_need_r, prev_need_nxt;
  logic [PAW-1:0]       first_r, first_nxt;
  in_t                  item_r, item_nxt;
  logic [ADDR_W-1:0]    base_r;
  out_t                 out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [WAW-1:0]       rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [WAW-1:0]       wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic [WORD_BITS-1:0] word_mask;
  logic [WORD_BITS-1:0] cur_free;
  scan_res_t            scan_res;
  logic signed [6:0]    run_start;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] cur_set;
  logic [WORD_BITS-1:0] bit_sel;
  logic                 accept;
  logic                 page_ok;
  logic                 len_ok;

  bpfa_map #(
    .WORDS(WORDS),
    .WAW  (WAW)
  ) u_map (
    .clk    (clk),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  bpfa_scan u_scan (
    .cur_free (cur_free),
    .prev_free(prev_free_r),
    .run_len  (item_r.run_length),
    .res      (scan_res)
  );

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign page_ok   = (32'(in_item.page_index) < 32'(NUM_PAGES));
  assign len_ok    = (in_item.run_length != '0) && (int'(in_item.run_length) <= MAX_RUN);

  // Page zero and pages past the end never count as free in the run search
  always_comb begin
    word_mask = '1;
    if (word_r == LAST_WORD) begin
      word_mask = TAIL_MASK;
    end
    if (word_r == '0) begin
      word_mask[0] = 1'b0;
    end
  end

  assign cur_free = ~rd_data & word_mask;

  always_comb begin
    run_start = $signed({2'b00, scan_res.pos}) - $signed({2'b00, item_r.run_length})
                + 7'sd1;
    lo_mask   = ~((WORD_BITS'(1) << run_start[4:0]) - WORD_BITS'(1));
    cur_set   = (32'hFFFF_FFFF >> (5'd31 - scan_res.pos))
                & ((run_start < 0) ? '1 : lo_mask);
    bit_sel   = WORD_BITS'(1) << item_r.page_index[4:0];
  end

  always_comb begin
    rd_addr = word_r;
    case (state_r)
      S_IDLE: begin
        if (in_item.func == FUNC_ALLOC || !page_ok) begin
          rd_addr = '0;
        end else begin
          rd_addr = WAW'(in_item.page_index >> 5);
        end
      end
      S_SCAN:  rd_addr = (word_r == LAST_WORD) ? word_r : word_r + WAW'(1);
      default: rd_addr = word_r;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = word_r;
    wr_data = '0;
    case (state_r)
      S_CLEAR: wr_en = 1'b1;
      S_SCAN: begin
        wr_en   = scan_res.hit;
        wr_data = rd_data | cur_set;
      end
      S_FIX: begin
        wr_en   = prev_need_r;
        wr_addr = word_r - WAW'(1);
        wr_data = prev_used_r | prev_set_r;
      end
      S_RMW: begin
        wr_en   = (item_r.func == FUNC_FREE) || (item_r.func == FUNC_MARK);
        wr_data = (item_r.func == FUNC_FREE) ? (rd_data & ~bit_sel) : (rd_data | bit_sel);
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    prev_used_nxt = prev_used_r;
    prev_free_nxt = prev_free_r;
    prev_set_nxt  = prev_set_r;
    prev_need_nxt = prev_need_r;
    first_nxt     = first_r;
    item_nxt      = item_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_CLEAR: begin
        word_nxt = word_r + WAW'(1);
        if (word_r == LAST_WORD) begin
          word_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          item_nxt      = in_item;
          word_nxt      = '0;
          prev_used_nxt = '0;
          prev_free_nxt = '0;
          out_nxt       = '0;
          if (in_item.func == FUNC_ALLOC) begin
            if (len_ok) begin
              state_nxt = S_SCAN;
            end else begin
              out_valid_nxt = 1'b1;
            end
          end else if (page_ok) begin
            word_nxt  = WAW'(in_item.page_index >> 5);
            state_nxt = S_RMW;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_RMW: begin
        out_nxt.ok        = 1'b1;
        out_nxt.page_free = (item_r.func == FUNC_QUERY) && ((rd_data & bit_sel) == '0);
        out_valid_nxt     = 1'b1;
        state_nxt         = S_IDLE;
      end
      S_SCAN: begin
        if (scan_res.hit) begin
          prev_need_nxt = (run_start < 0);
          prev_set_nxt  = (run_start < 0) ? lo_mask : '0;
          first_nxt     = PAW'({word_r, 5'b0}) + PAW'(scan_res.pos) + PAW'(1)
                          - PAW'(item_r.run_length);
          state_nxt     = S_FIX;
        end else if (word_r == LAST_WORD) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          // advance: this word becomes the look-back window
          prev_used_nxt = rd_data;
          prev_free_nxt = cur_free;
          word_nxt      = word_r + WAW'(1);
        end
      end
      S_FIX: begin
        out_nxt.address = base_r + (ADDR_W'(first_r) << PAGE_SHIFT);
        out_nxt.ok      = 1'b1;
        out_valid_nxt   = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      word_r      <= '0;
      out_valid_r <= 1'b0;
      prev_need_r <= 1'b0;
      base_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      out_valid_r <= out_valid_nxt;
      prev_need_r <= prev_need_nxt;
      if (cfg_valid && cfg_ready) begin
        base_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    prev_used_r <= prev_used_nxt;
    prev_free_r <= prev_free_nxt;
    prev_set_r  <= prev_set_nxt;
    first_r     <= first_nxt;
    item_r      <= item_nxt;
    out_r       <= out_nxt;
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !wr_en)
    else $error("map written while idle");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (word_r <= LAST_WORD))
    else $error("scan word past end of map");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither in progress nor answered");

  a_free_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.page_free) |-> out_item.ok)
    else $error("page_free reported on failed item");

endmodule

### src/bpfa_map.sv
// ----------------------------------------------------------------------------
// bpfa_map
// Used-page map storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bpfa_map
  import bpfa_pkg::*;
#(
  parameter int WORDS = 128,
  parameter int WAW   = 7
) (
  input  logic                 clk,
  input  logic [WAW-1:0]       rd_addr,
  output logic [WORD_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [WAW-1:0]       wr_addr,
  input  logic [WORD_BITS-1:0] wr_data
);

  logic [WORD_BITS-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### src/bpfa_scan.sv
// ----------------------------------------------------------------------------
// bpfa_scan
// Finds the lowest bit of the current map word where a free run of the
// requested length ends, looking back into the previous word.
// ----------------------------------------------------------------------------
module bpfa_scan
  import bpfa_pkg::*;
(
  input  logic [WORD_BITS-1:0] cur_free,
  input  logic [WORD_BITS-1:0] prev_free,
  input  logic [RUN_LEN_W-1:0] run_len,
  output scan_res_t            res
);

  logic [2*WORD_BITS-1:0] pw [RUN_LEN_W];
  logic [2*WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0]   hits;
  logic [4:0]             off;

  always_comb begin
    // pw[k] bit j: 2**k free pages end at position j
    pw[0] = {cur_free, prev_free};
    for (int k = 1; k < RUN_LEN_W; k++) begin
      pw[k] = pw[k-1] & (pw[k-1] << (1 << (k-1)));
    end
    // stitch power-of-two segments into one run of run_len pages
    acc = '1;
    for (int b = 0; b < RUN_LEN_W; b++) begin
      off = run_len & 5'((1 << b) - 1);
      if (run_len[b]) begin
        acc = acc & (pw[b] << off);
      end
    end
    hits = acc[2*WORD_BITS-1:WORD_BITS];
    res.hit = |hits;
    res.pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (hits[i]) begin
        res.pos = 5'(i);
      end
    end
  end

endmodule
